>>> hdl/fse_pkg.sv
package fse_pkg;

    // code table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = 8;
    localparam int CODE_W      = 8;
    localparam int ALPHA_W     = 9;

    // output field widths
    localparam int VALUE_W  = 8;
    localparam int INDEX_W  = 16;
    localparam int SCOUNT_W = 32;

    // stream widths
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 2;

    // characters of interest
    localparam logic [7:0] CH_GT  = 8'h3E;
    localparam logic [7:0] CH_US  = 8'h5F;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_UA  = 8'h41;
    localparam logic [7:0] CH_UZ  = 8'h5A;
    localparam logic [7:0] CH_LA  = 8'h61;
    localparam logic [7:0] CH_LZ  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // input action codes
    localparam logic [1:0] ACT_TEXT    = 2'd0;
    localparam logic [1:0] ACT_END     = 2'd1;
    localparam logic [1:0] ACT_PRELOAD = 2'd2;

    typedef enum logic [1:0] {
        PH_SEEK   = 2'd0,
        PH_HEADER = 2'd1,
        PH_BODY   = 2'd2,
        PH_HALT   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NAME = 2'd0,
        KIND_SYM  = 2'd1,
        KIND_END  = 2'd2,
        KIND_ERR  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [VALUE_W-1:0]   value;
        logic [INDEX_W-1:0]   record_index;
        logic [SCOUNT_W-1:0]  symbol_count;
        logic                 kept;
        logic [ALPHA_W-1:0]   alphabet_size;
    } res_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CODE_W-1:0] code;
    } tbl_wr_t;

    // ascii lower case folded to upper case
    function automatic logic [7:0] upcase(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= CH_LA && b <= CH_LZ) begin
            r = b - CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

>>> hdl/fse_ram.sv
module fse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/fse_step.sv
module fse_step #(
    parameter int MIN_SYMBOLS  = 1,
    parameter int COUNT_WIDTH  = 32,
    parameter int RECORD_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rstn,
    input  logic                 allow_new,
    input  logic                 item_valid,
    input  logic [1:0]           item_action,
    input  logic [7:0]           item_byte,
    input  logic [7:0]           lookup_code,
    input  logic                 commit,
    output logic                 has_result,
    output fse_pkg::res_t        res,
    output fse_pkg::tbl_wr_t     wr
);

    import fse_pkg::*;

    localparam int CMP_W = COUNT_WIDTH + 11;

    phase_t                  phase_reg, phase_next;
    logic [ALPHA_W-1:0]      assigned_reg, assigned_next;
    logic [COUNT_WIDTH-1:0]  count_reg, count_next, count_inc;
    logic [RECORD_WIDTH-1:0] kept_reg, kept_next;
    logic                    preloaded_reg, preloaded_next;
    logic [TABLE_DEPTH-1:0]  valid_reg, valid_next;

    logic [7:0]                  ub;
    logic                        keep;
    logic [COUNT_WIDTH+SCOUNT_W-1:0] cnt_now_wide, cnt_inc_wide;
    logic [RECORD_WIDTH+INDEX_W-1:0] rec_wide;

    // per byte helpers
    assign ub        = upcase(item_byte);
    assign count_inc = (count_reg == {COUNT_WIDTH{1'b1}}) ? count_reg
                                                          : count_reg + COUNT_WIDTH'(1);
    assign keep      = CMP_W'(count_reg) >= CMP_W'(MIN_SYMBOLS);

    // zero extend or truncate to the output field widths
    assign cnt_now_wide = {{SCOUNT_W{1'b0}}, count_reg};
    assign cnt_inc_wide = {{SCOUNT_W{1'b0}}, count_inc};
    assign rec_wide     = {{INDEX_W{1'b0}}, kept_reg};

    // one input item worth of work
    always_comb begin
        phase_next     = phase_reg;
        assigned_next  = assigned_reg;
        count_next     = count_reg;
        kept_next      = kept_reg;
        preloaded_next = preloaded_reg;
        valid_next     = valid_reg;
        has_result     = 1'b0;
        wr             = '0;
        res.kind          = KIND_NAME;
        res.value         = '0;
        res.record_index  = rec_wide[INDEX_W-1:0];
        res.symbol_count  = cnt_now_wide[SCOUNT_W-1:0];
        res.kept          = 1'b0;
        res.alphabet_size = assigned_reg;
        if (item_valid && phase_reg != PH_HALT) begin
            case (item_action)
                ACT_PRELOAD: begin
                    if (!assigned_reg[ALPHA_W-1]) begin
                        wr.en          = 1'b1;
                        wr.addr        = item_byte;
                        wr.code        = assigned_reg[CODE_W-1:0];
                        valid_next[item_byte] = 1'b1;
                        assigned_next  = assigned_reg + ALPHA_W'(1);
                        preloaded_next = 1'b1;
                    end
                end
                ACT_END: begin
                    if (phase_reg != PH_SEEK) begin
                        phase_next = PH_SEEK;
                        has_result = 1'b1;
                        res.kind   = KIND_END;
                        res.kept   = keep;
                        count_next = '0;
                        if (keep) begin
                            kept_next = kept_reg + RECORD_WIDTH'(1);
                        end
                    end
                end
                ACT_TEXT: begin
                    case (phase_reg)
                        PH_SEEK: begin
                            if (item_byte == CH_GT) begin
                                phase_next = PH_HEADER;
                                count_next = '0;
                            end
                        end
                        PH_HEADER: begin
                            if (item_byte == CH_LF || item_byte == CH_CR) begin
                                phase_next = PH_BODY;
                            end else begin
                                has_result = 1'b1;
                                res.kind   = KIND_NAME;
                                if (item_byte inside {CH_SP, CH_TAB, CH_VT, CH_FF}) begin
                                    res.value = CH_US;
                                end else begin
                                    res.value = item_byte;
                                end
                            end
                        end
                        PH_BODY: begin
                            if (item_byte == CH_GT) begin
                                // header of the next record closes this one
                                phase_next = PH_HEADER;
                                has_result = 1'b1;
                                res.kind   = KIND_END;
                                res.kept   = keep;
                                count_next = '0;
                                if (keep) begin
                                    kept_next = kept_reg + RECORD_WIDTH'(1);
                                end
                            end else if (ub >= CH_UA && ub <= CH_UZ) begin
                                has_result = 1'b1;
                                if (valid_reg[ub]) begin
                                    res.kind         = KIND_SYM;
                                    res.value        = lookup_code;
                                    count_next       = count_inc;
                                    res.symbol_count = cnt_inc_wide[SCOUNT_W-1:0];
                                end else if ((!allow_new && preloaded_reg)
                                             || assigned_reg[ALPHA_W-1]) begin
                                    phase_next = PH_HALT;
                                    res.kind   = KIND_ERR;
                                    res.value  = ub;
                                end else begin
                                    // unseen letter takes the next code
                                    wr.en             = 1'b1;
                                    wr.addr           = ub;
                                    wr.code           = assigned_reg[CODE_W-1:0];
                                    valid_next[ub]    = 1'b1;
                                    assigned_next     = assigned_reg + ALPHA_W'(1);
                                    res.kind          = KIND_SYM;
                                    res.value         = assigned_reg[CODE_W-1:0];
                                    res.alphabet_size = assigned_reg + ALPHA_W'(1);
                                    count_next        = count_inc;
                                    res.symbol_count  = cnt_inc_wide[SCOUNT_W-1:0];
                                end
                            end
                        end
                        default: begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // state update when the item leaves the stage
    always_ff @(posedge clk) begin
        if (!rstn) begin
            phase_reg     <= PH_SEEK;
            assigned_reg  <= '0;
            count_reg     <= '0;
            kept_reg      <= '0;
            preloaded_reg <= 1'b0;
            valid_reg     <= '0;
        end else if (commit) begin
            phase_reg     <= phase_next;
            assigned_reg  <= assigned_next;
            count_reg     <= count_next;
            kept_reg      <= kept_next;
            preloaded_reg <= preloaded_next;
            valid_reg     <= valid_next;
        end
    end

endmodule

>>> hdl/fasta_symbol_encoder.sv
// FASTA symbol encoder. Text bytes enter on the s_ stream one per transfer and
// leave as name bytes, symbol codes, end-of-record reports or one unknown-symbol
// error on the m_ stream; an item that makes no result produces no transfer.
// One item is taken every cycle while results are being taken. An item's result
// passes through the input stage and then the result register, which offers it.
// The rate is set by the code table: a 256 entry RAM read at the input transfer
// and written from the input stage, with a one-entry bypass for back to back
// bytes that hit the same letter. Assigned-entry flags sit in flip-flops that
// reset clears, so the block takes items as soon as reset is released.
// allow_new_symbols (cfg_data) resets to 1 and should be written only while
// the block is idle. After an error result the block ignores all input until
// reset.
module fasta_symbol_encoder #(
    parameter int MIN_SYMBOLS  = 1,
    parameter int COUNT_WIDTH  = 32,
    parameter int RECORD_WIDTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration: allow_new_symbols
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_data,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fse_pkg::S_TDATA_W-1:0]   s_tdata,   // data_byte[7:0]
    input  logic [fse_pkg::S_TUSER_W-1:0]   s_tuser,   // action[1:0]
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // value[7:0], record_index[23:8], symbol_count[55:24], kept[56],
    // alphabet_size[65:57], zero[71:66]
    output logic [fse_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [fse_pkg::M_TUSER_W-1:0]   m_tuser    // kind[1:0]
);

    import fse_pkg::*;

    logic              allow_reg;
    logic              in_valid_reg;
    logic [1:0]        in_action_reg;
    logic [7:0]        in_byte_reg;
    logic              byp_hit_reg;
    logic [CODE_W-1:0] byp_code_reg;
    logic              m_valid_reg;
    res_t              m_res_reg;

    logic              accept;
    logic              commit;
    logic              has_result;
    res_t              res;
    tbl_wr_t           wr;
    logic [CODE_W-1:0] ram_q;
    logic [CODE_W-1:0] lookup_code;
    logic [ADDR_W-1:0] rd_addr;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            allow_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            allow_reg <= cfg_data;
        end
    end

    // handshake between the input stage and the result register
    assign commit   = in_valid_reg && (!has_result || !m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || commit;
    assign accept   = s_tvalid && s_tready;
    assign rd_addr  = upcase(s_tdata);

    // code table
    fse_ram #(
        .WIDTH (CODE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (aclk),
        .we    (wr.en && commit),
        .waddr (wr.addr),
        .wdata (wr.code),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    assign lookup_code = byp_hit_reg ? byp_code_reg : ram_q;

    // input stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (accept) begin
            in_valid_reg <= 1'b1;
        end else if (commit) begin
            in_valid_reg <= 1'b0;
        end
    end

    // input stage payload and write bypass
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_action_reg <= s_tuser;
            in_byte_reg   <= s_tdata;
            byp_hit_reg   <= wr.en && commit && (wr.addr == rd_addr);
            byp_code_reg  <= wr.code;
        end
    end

    fse_step #(
        .MIN_SYMBOLS  (MIN_SYMBOLS),
        .COUNT_WIDTH  (COUNT_WIDTH),
        .RECORD_WIDTH (RECORD_WIDTH)
    ) u_step (
        .clk         (aclk),
        .rstn        (aresetn),
        .allow_new   (allow_reg),
        .item_valid  (in_valid_reg),
        .item_action (in_action_reg),
        .item_byte   (in_byte_reg),
        .lookup_code (lookup_code),
        .commit      (commit),
        .has_result  (has_result),
        .res         (res),
        .wr          (wr)
    );

    // result register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit && has_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (commit && has_result) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.kind;
    assign m_tdata  = {6'b0, m_res_reg.alphabet_size, m_res_reg.kept,
                       m_res_reg.symbol_count, m_res_reg.record_index, m_res_reg.value};

endmodule

>>> hdl/fse_checker.sv
module fse_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [fse_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [fse_pkg::M_TUSER_W-1:0] m_tuser
);

    import fse_pkg::*;

    logic halted_reg;

    // remember that an error result has gone out
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            halted_reg <= 1'b0;
        end else if (m_tvalid && m_tready && m_tuser == KIND_ERR) begin
            halted_reg <= 1'b1;
        end
    end

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // nothing follows an error
    a_halt: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |-> !m_tvalid)
        else $error("result after unknown symbol error");

    // alphabet never grows past the table
    a_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[65:57] <= 9'd256)
        else $error("alphabet size beyond table");

    // kept flag only on end of record
    a_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_END |-> !m_tdata[56])
        else $error("kept flag outside end of record");

    // header bytes come before any symbol of the record
    a_name: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_NAME |-> m_tdata[55:24] == 32'd0)
        else $error("name byte with nonzero symbol count");

endmodule

bind fasta_symbol_encoder fse_checker u_fse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> tb/sv/fasta_symbol_encoder_tb.sv
module fasta_symbol_encoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fse_pkg::*;

    localparam int CLK_HALF         = 10;
    localparam int RESET_CYCLES     = 2;
    localparam int SETTLE_CYCLES    = 8;
    localparam int TIMEOUT_NS       = 2000000;
    localparam int MIN_SYMBOLS      = 1;
    localparam int PHASE_ITEMS      = 60;
    localparam int PHASE_ITEMS_FILL = 30;
    localparam int HOLD_AT          = 60;
    localparam int HOLD_CYCLES      = 150;
    localparam int MAX_REPORTS      = 10;

    // action value that the block has no use for
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    // code table entry that no byte has claimed yet
    localparam logic [8:0] CODE_FREE  = 9'h100;
    localparam logic [7:0] CH_STAR    = 8'h2A;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data;
    } text_item_t;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic                       cfg_data  = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [S_TDATA_W-1:0]       s_tdata   = '0;   // data_byte[7:0]
    logic [S_TUSER_W-1:0]       s_tuser   = '0;   // action[1:0]
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    // value[7:0], record_index[23:8], symbol_count[55:24], kept[56],
    // alphabet_size[65:57], zero[71:66]
    logic [M_TDATA_W-1:0]       m_tdata;
    logic [M_TUSER_W-1:0]       m_tuser;          // kind[1:0]

    // bytes waiting for the input stream, and the results they must give
    text_item_t text_q[$];
    res_t       encoded_q[$];
    text_item_t drv_item;

    int tx_idle_pct = 38;
    int rx_idle_pct = 65;
    int n_accepted  = 0;
    int n_err       = 0;
    int total_fed   = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;

    // encoder state as seen by the checker
    logic       enc_allow;
    phase_t     enc_phase;
    logic [8:0] enc_tab [0:TABLE_DEPTH-1];
    logic [8:0] enc_codes;
    logic [31:0] enc_count;
    logic [15:0] enc_kept;
    logic       enc_loaded;

    // coarse copy kept by the stimulus side so that no letter halts the block early
    logic       gen_allow  = 1'b1;
    phase_t     gen_phase  = PH_SEEK;
    logic [25:0] gen_known = '0;
    int         gen_codes  = 0;
    logic       gen_loaded = 1'b0;

    fasta_symbol_encoder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #CLK_HALF aclk = ~aclk;

    task automatic clear_encoder();
        enc_allow  = 1'b1;
        enc_phase  = PH_SEEK;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            enc_tab[i] = CODE_FREE;
        end
        enc_codes  = '0;
        enc_count  = '0;
        enc_kept   = '0;
        enc_loaded = 1'b0;
    endtask

    function automatic res_t make_res(kind_t k, logic [7:0] v, logic kp);
        res_t r;
        r.kind          = k;
        r.value         = v;
        r.record_index  = enc_kept;
        r.symbol_count  = enc_count;
        r.kept          = kp;
        r.alphabet_size = enc_codes;
        return r;
    endfunction

    // report the record length, then bump the kept count if it qualifies
    task automatic close_record();
        logic keep;
        keep = (enc_count >= MIN_SYMBOLS);
        encoded_q.push_back(make_res(KIND_END, 8'h00, keep));
        if (keep) begin
            enc_kept = enc_kept + 1'b1;
        end
        enc_count = '0;
    endtask

    // one accepted input transfer through the encoder
    task automatic encode_byte(input logic [1:0] act, input logic [7:0] b);
        logic [7:0] u;
        u = b;
        if (enc_phase != PH_HALT) begin
            case (act)
                ACT_PRELOAD: begin
                    // stored as given; a repeated byte simply takes the new code
                    if (enc_codes < TABLE_DEPTH) begin
                        enc_tab[b] = enc_codes;
                        enc_codes  = enc_codes + 1'b1;
                        enc_loaded = 1'b1;
                    end
                end
                ACT_END: begin
                    if (enc_phase != PH_SEEK) begin
                        enc_phase = PH_SEEK;
                        close_record();
                    end
                end
                ACT_TEXT: begin
                    case (enc_phase)
                        PH_SEEK: begin
                            if (b == CH_GT) begin
                                enc_phase = PH_HEADER;
                                enc_count = '0;
                            end
                        end
                        PH_HEADER: begin
                            if (b == CH_LF || b == CH_CR) begin
                                enc_phase = PH_BODY;
                            end else begin
                                if (b == CH_SP || b == CH_TAB || b == CH_VT || b == CH_FF) begin
                                    u = CH_US;
                                end
                                encoded_q.push_back(make_res(KIND_NAME, u, 1'b0));
                            end
                        end
                        default: begin
                            if (b == CH_GT) begin
                                enc_phase = PH_HEADER;
                                close_record();
                            end else begin
                                if (b >= CH_LA && b <= CH_LZ) begin
                                    u = b - CASE_OFFSET;
                                end
                                if (u >= CH_UA && u <= CH_UZ) begin
                                    // unseen letter: grow the table or stop for good
                                    if (enc_tab[u][8]) begin
                                        if ((!enc_allow && enc_loaded) ||
                                            enc_codes >= TABLE_DEPTH) begin
                                            enc_phase = PH_HALT;
                                            encoded_q.push_back(make_res(KIND_ERR, u, 1'b0));
                                        end else begin
                                            enc_tab[u] = enc_codes;
                                            enc_codes  = enc_codes + 1'b1;
                                        end
                                    end
                                    if (enc_phase != PH_HALT) begin
                                        if (enc_count != '1) begin
                                            enc_count = enc_count + 1'b1;
                                        end
                                        encoded_q.push_back(
                                            make_res(KIND_SYM, enc_tab[u][7:0], 1'b0));
                                    end
                                end
                            end
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    endtask

    task automatic compare_result(input logic [1:0] kind, input logic [M_TDATA_W-1:0] d);
        res_t want;
        if (encoded_q.size() == 0) begin
            n_err++;
            if (n_err <= MAX_REPORTS) begin
                $display("%0t: result with nothing expected, kind %0d tdata %h",
                         $time, kind, d);
            end
        end else begin
            want = encoded_q.pop_front();
            if (want.kind !== kind || want.value !== d[7:0] ||
                want.record_index !== d[23:8] || want.symbol_count !== d[55:24] ||
                want.kept !== d[56] || want.alphabet_size !== d[65:57]) begin
                n_err++;
                if (n_err <= MAX_REPORTS) begin
                    $display(
                        "%0t: exp kind %0d value %h index %0d count %0d kept %0d alpha %0d",
                        $time, want.kind, want.value, want.record_index,
                        want.symbol_count, want.kept, want.alphabet_size);
                    $display(
                        "%0t: got kind %0d value %h index %0d count %0d kept %0d alpha %0d",
                        $time, kind, d[7:0], d[23:8], d[55:24], d[56], d[65:57]);
                end
            end
        end
    endtask

    // queue one item, steering body letters away from an early halt
    task automatic feed(input logic [1:0] act, input logic [7:0] b);
        logic [7:0] u;
        int         k;
        u = b;
        if (act == ACT_PRELOAD) begin
            if (gen_codes < TABLE_DEPTH) begin
                gen_codes++;
                gen_loaded = 1'b1;
                if (b >= CH_UA && b <= CH_UZ) begin
                    gen_known[b - CH_UA] = 1'b1;
                end
            end
        end else if (act == ACT_END) begin
            gen_phase = PH_SEEK;
        end else if (act == ACT_TEXT) begin
            case (gen_phase)
                PH_SEEK: begin
                    if (b == CH_GT) begin
                        gen_phase = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    if (b == CH_LF || b == CH_CR) begin
                        gen_phase = PH_BODY;
                    end
                end
                default: begin
                    if (b == CH_GT) begin
                        gen_phase = PH_HEADER;
                    end else begin
                        if (b >= CH_LA && b <= CH_LZ) begin
                            u = b - CASE_OFFSET;
                        end
                        if (u >= CH_UA && u <= CH_UZ && !gen_known[u - CH_UA]) begin
                            // z is saved for the closing error
                            if (u == CH_UZ || gen_codes >= TABLE_DEPTH ||
                                (!gen_allow && gen_loaded)) begin
                                b = CH_STAR;
                                if (gen_known != '0) begin
                                    do begin
                                        k = $urandom_range(25);
                                    end while (!gen_known[k]);
                                    b = CH_UA + 8'(k);
                                end
                            end else begin
                                gen_known[u - CH_UA] = 1'b1;
                                gen_codes++;
                            end
                        end
                    end
                end
            endcase
        end
        text_q.push_back({act, b});
        total_fed++;
    endtask

    // one record, now and then with noise or a broken ending
    task automatic feed_record();
        int         style;
        int         n;
        logic [7:0] b;
        style = $urandom_range(99);
        if (style < 6) begin
            repeat ($urandom_range(3, 1)) feed(ACT_TEXT, 8'($urandom_range(255)));
        end else if (style < 9) begin
            feed(ACT_UNUSED, 8'($urandom_range(255)));
        end else if (style < 12) begin
            feed(ACT_END, 8'($urandom_range(255)));
        end else if (style < 18 && gen_codes < 200) begin
            b = 8'($urandom_range(255));
            if (b == CH_UZ) begin
                b = CH_UA;
            end
            feed(ACT_PRELOAD, b);
        end
        feed(ACT_TEXT, CH_GT);
        n = $urandom_range(6);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
                0: b = 8'($urandom_range(255));
                1: begin
                    case ($urandom_range(3))
                        0: b = CH_SP;
                        1: b = CH_TAB;
                        2: b = CH_VT;
                        default: b = CH_FF;
                    endcase
                end
                default: b = 8'($urandom_range(126, 33));
            endcase
            if (b == CH_LF || b == CH_CR) begin
                b = CH_US;
            end
            feed(ACT_TEXT, b);
        end
        if (style >= 94) begin
            // header cut short by end of input
            feed(ACT_END, 8'($urandom_range(255)));
        end else begin
            case ($urandom_range(2))
                0: feed(ACT_TEXT, CH_LF);
                1: feed(ACT_TEXT, CH_CR);
                default: begin
                    feed(ACT_TEXT, CH_CR);
                    feed(ACT_TEXT, CH_LF);
                end
            endcase
            n = ($urandom_range(9) == 0) ? 0 : $urandom_range(16, 1);
            for (int i = 0; i < n; i++) begin
                k_pick: begin
                    int r;
                    r = $urandom_range(9);
                    if (r < 8) begin
                        b = CH_UA + 8'($urandom_range(24));
                        if ($urandom_range(1)) begin
                            b = b + CASE_OFFSET;
                        end
                    end else if (r == 8) begin
                        b = CH_LF;
                    end else begin
                        b = 8'($urandom_range(255));
                        if (b == CH_GT) begin
                            b = CH_STAR;
                        end
                    end
                end
                feed(ACT_TEXT, b);
            end
            if (style >= 88) begin
                feed(ACT_END, 8'($urandom_range(255)));
            end
        end
    endtask

    // wait until the block has nothing left in flight
    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (text_q.size() != 0 || s_tvalid || encoded_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_allow(input logic v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        enc_allow  = v;
        gen_allow  = v;
        @(negedge aclk);
    endtask

    // input stream driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end else if (!s_tvalid || s_tready) begin
            if (text_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                drv_item = text_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= drv_item.data;
                s_tuser  <= drv_item.action;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // one long receiver hold-off while items keep coming
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_accepted >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result stream receiver
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // monitor: predict on each input transfer, check each result transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_encoder();
        end else begin
            if (s_tvalid && s_tready) begin
                encode_byte(s_tuser, s_tdata);
                n_accepted <= n_accepted + 1;
            end
            if (m_tvalid && m_tready) begin
                compare_result(m_tuser, m_tdata);
            end
        end
    end

    initial begin
        #TIMEOUT_NS;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int ph;
        bit fill_close;
        // the full-table ending costs many preloads, so the random phases shrink
        fill_close = 1'($urandom_range(1));
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // no alphabet loaded yet, so letters grow the table even with growth off
        write_allow(1'b0);
        feed(ACT_TEXT, "x");
        feed(ACT_END, 8'hFF);
        feed(ACT_UNUSED, 8'h00);
        feed(ACT_TEXT, CH_GT);
        feed(ACT_TEXT, CH_SP);
        feed(ACT_TEXT, CH_TAB);
        feed(ACT_TEXT, CH_VT);
        feed(ACT_TEXT, CH_FF);
        feed(ACT_TEXT, 8'hFF);
        feed(ACT_TEXT, CH_CR);
        feed(ACT_TEXT, "a");
        feed(ACT_TEXT, "G");
        feed(ACT_TEXT, "7");
        feed(ACT_TEXT, CH_LF);
        feed(ACT_TEXT, "a");
        feed(ACT_TEXT, CH_GT);
        feed(ACT_TEXT, CH_LF);
        // empty record closed by the next header
        feed(ACT_TEXT, CH_GT);
        feed(ACT_TEXT, 8'h00);
        // end of input inside a header
        feed(ACT_END, 8'h00);
        wait_idle();

        // alphabet preload, stored as given, with a repeated byte
        write_allow(1'b1);
        feed(ACT_PRELOAD, "C");
        feed(ACT_PRELOAD, "c");
        feed(ACT_PRELOAD, "C");
        feed(ACT_TEXT, CH_GT);
        feed(ACT_TEXT, CH_LF);
        feed(ACT_TEXT, "c");
        feed(ACT_TEXT, "t");
        feed(ACT_END, 8'h00);

        // random records across growth settings and idle patterns
        for (ph = 0; ph < 6; ph++) begin
            wait_idle();
            case (ph / 2)
                0: begin
                    tx_idle_pct = 38;
                    rx_idle_pct = 65;
                end
                1: begin
                    tx_idle_pct = 65;
                    rx_idle_pct = 38;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            write_allow(ph % 2 == 0 ? 1'b0 : 1'b1);
            total_fed = 0;
            while (total_fed < (fill_close ? PHASE_ITEMS_FILL : PHASE_ITEMS)) begin
                feed_record();
            end
        end
        wait_idle();

        // close with the one error the run can afford: full table or growth off
        if (fill_close) begin
            while (gen_codes < TABLE_DEPTH) begin
                drv_fill: begin
                    logic [7:0] b;
                    b = 8'($urandom_range(255));
                    if (b == CH_UZ) begin
                        b = CH_UA;
                    end
                    feed(ACT_PRELOAD, b);
                end
            end
            // table full: further preloads do nothing
            repeat (3) feed(ACT_PRELOAD, 8'($urandom_range(255)));
        end else begin
            write_allow(1'b0);
        end
        feed(ACT_TEXT, CH_GT);
        feed(ACT_TEXT, "e");
        feed(ACT_TEXT, CH_LF);
        feed(ACT_TEXT, "a");
        feed(ACT_TEXT, "c");
        text_q.push_back({ACT_TEXT, CH_LZ});
        // halted: all of these are dropped silently
        text_q.push_back({ACT_TEXT, CH_GT});
        text_q.push_back({ACT_END, 8'h00});
        text_q.push_back({ACT_PRELOAD, CH_UZ});
        text_q.push_back({ACT_UNUSED, 8'hFF});
        text_q.push_back({ACT_TEXT, CH_UA});
        wait_idle();

        if (n_err == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/fse_pkg.sv
hdl/fse_ram.sv
hdl/fse_step.sv
hdl/fasta_symbol_encoder.sv
hdl/fse_checker.sv
tb/sv/fasta_symbol_encoder_tb.sv
